FILE: rtl/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types and constants of the Poisson likelihood flash matcher.
// ----------------------------------------------------------------------------
package plm_pkg;

    localparam int          CHANNELS_DEF = 32;
    localparam logic [15:0] SCALE_RESET  = 16'd4096;
    localparam logic [31:0] E_FLOOR      = 32'd66;
    localparam logic [31:0] LN2_Q32      = 32'd2977044472;
    localparam int          QUEUE_DEPTH  = 4;

    typedef struct packed {
        logic [15:0] obs;
        logic [31:0] expv;
        logic        lc;
        logic        lf;
    } entry_t;

    typedef struct packed {
        logic [24:0] total_expected;
        logic [20:0] best_total_observed;
        logic [31:0] best_score;
        logic [31:0] flash_score;
        logic        set_done;
    } result_t;

    function automatic int avg_shift(input int ch);
        int s;
        s = 0;
        for (int i = 0; i < 30; i++) begin
            if ((ch >> (s + 1)) != 0) begin
                s = s + 1;
            end
        end
        return s;
    endfunction

endpackage

FILE: rtl/plm_front.sv
// ----------------------------------------------------------------------------
// plm_front
// Accepts channel requests, scales the hypothesis and forwards the entry.
// ----------------------------------------------------------------------------
module plm_front
    import plm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] obs,
    input  logic [15:0] hypo,
    input  logic        lc,
    input  logic        lf,
    input  logic        cfg_valid,
    input  logic [15:0] cfg_data,
    input  logic        q_full,
    output logic        q_push,
    output entry_t      q_entry
);

    logic [15:0] scale_reg;
    logic        fv_reg;
    entry_t      entry_reg;

    assign q_push  = fv_reg && !q_full;
    assign s_ready = !fv_reg || !q_full;
    assign q_entry = entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
            fv_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                scale_reg <= cfg_data;
            end
            if (s_valid && s_ready) begin
                fv_reg <= 1'b1;
            end else if (q_push) begin
                fv_reg <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            entry_reg.obs  <= obs;
            entry_reg.expv <= 32'(hypo) * 32'(scale_reg);
            entry_reg.lc   <= lc;
            entry_reg.lf   <= lf;
        end
    end

endmodule

FILE: rtl/plm_queue.sv
// ----------------------------------------------------------------------------
// plm_queue
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
module plm_queue
    import plm_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t din,
    output logic   full,
    input  logic   pop,
    output logic   dvalid,
    output entry_t dout
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    entry_t        mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wptr_reg;
    logic [AW-1:0] rptr_reg;
    logic [AW:0]   cnt_reg;

    assign full   = (cnt_reg == (AW+1)'(QUEUE_DEPTH));
    assign dvalid = (cnt_reg != '0);
    assign dout   = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

FILE: rtl/plm_back.sv
// ----------------------------------------------------------------------------
// plm_back
// Computes each channel term with an iterative log unit, accumulates the
// flash score and holds the result register.
// ----------------------------------------------------------------------------
module plm_back
    import plm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    input  entry_t  q_data,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam int AVG_SHIFT = avg_shift(CHANNELS);

    typedef enum logic [2:0] {S_IDLE, S_NORM, S_SQR, S_LNMUL, S_OMUL, S_FIN} state_t;

    state_t             state_reg;
    entry_t             ent_reg;
    logic [31:0]        ef_reg;
    logic [31:0]        v_reg;
    logic [4:0]         p_reg;
    logic [3:0]         rnd_reg;
    logic [15:0]        frac_reg;
    logic               second_reg;
    logic signed [21:0] l1_reg;
    logic [22:0]        mag_reg;
    logic               neg_reg;
    logic [22:0]        lnr_reg;
    logic signed [40:0] olnr_reg;
    logic signed [39:0] acc_reg;
    logic [21:0]        obs_tot_reg;
    logic [24:0]        exp_tot_reg;
    logic [31:0]        best_reg;
    logic [21:0]        best_obs_reg;
    logic               have_best_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    logic [31:0]        ef_in;
    logic [63:0]        sq;
    logic [32:0]        t;
    logic [15:0]        frac_next;
    logic [5:0]         pm16;
    logic signed [21:0] logv;
    logic signed [22:0] d;
    logic [54:0]        lnprod;
    logic signed [23:0] lnr_s;
    logic signed [41:0] s_sum;
    logic signed [41:0] term;
    logic signed [41:0] acc_sum;
    logic signed [39:0] acc_next;
    logic signed [39:0] acc_sh;
    logic [31:0]        score;
    logic [22:0]        obs_sum;
    logic [21:0]        obs_next;
    logic [25:0]        exp_sum;
    logic [24:0]        exp_next;
    logic               take_best;
    logic [21:0]        best_obs_new;
    logic               fin_go;
    logic               fin_emit;

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb begin
        ef_in     = (q_data.obs != '0 && q_data.expv == '0) ? E_FLOOR : q_data.expv;
        sq        = 64'(v_reg) * 64'(v_reg);
        t         = sq[63:31];
        frac_next = {frac_reg[14:0], t[32]};
        pm16      = {1'b0, p_reg} - 6'd16;
        logv      = $signed({pm16, frac_next});
        d         = 23'(l1_reg) - 23'(logv);
        lnprod    = 55'(mag_reg) * 55'(LN2_Q32);
        lnr_s     = neg_reg ? -$signed({1'b0, lnr_reg}) : $signed({1'b0, lnr_reg});
        s_sum     = $signed({6'b0, ef_reg, 4'b0}) - $signed({10'b0, ent_reg.obs, 16'b0})
                    + 42'(olnr_reg);
        term      = s_sum >>> 11;
        acc_sum   = 42'(acc_reg) + term;
        if (acc_sum > 42'sh7F_FFFF_FFFF) begin
            acc_next = 40'sh7F_FFFF_FFFF;
        end else if (acc_sum < -42'sh80_0000_0000) begin
            acc_next = -40'sh80_0000_0000;
        end else begin
            acc_next = acc_sum[39:0];
        end
        acc_sh = acc_next >>> AVG_SHIFT;
        if (acc_sh < 0) begin
            score = '0;
        end else if (acc_sh[39:32] != '0) begin
            score = '1;
        end else begin
            score = acc_sh[31:0];
        end
        obs_sum  = {1'b0, obs_tot_reg} + {7'b0, ent_reg.obs};
        obs_next = obs_sum[22] ? '1 : obs_sum[21:0];
        exp_sum  = {1'b0, exp_tot_reg} + {6'b0, ent_reg.expv[31:12]};
        exp_next = exp_sum[25] ? '1 : exp_sum[24:0];
        take_best    = !have_best_reg || (score < best_reg);
        best_obs_new = take_best ? obs_next : best_obs_reg;
        fin_go       = !(ent_reg.lc && out_valid_reg && !out_ready);
        fin_emit     = (state_reg == S_FIN) && fin_go && ent_reg.lc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            obs_tot_reg   <= '0;
            exp_tot_reg   <= '0;
            best_reg      <= '0;
            best_obs_reg  <= '0;
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fin_emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        ent_reg    <= q_data;
                        ef_reg     <= ef_in;
                        v_reg      <= {4'b0, q_data.obs, 12'b0};
                        p_reg      <= 5'd31;
                        second_reg <= 1'b0;
                        olnr_reg   <= '0;
                        state_reg  <= (q_data.obs == '0) ? S_FIN : S_NORM;
                    end
                end
                S_NORM: begin
                    if (v_reg[31] || p_reg == '0) begin
                        rnd_reg   <= '0;
                        frac_reg  <= '0;
                        state_reg <= S_SQR;
                    end else begin
                        v_reg <= {v_reg[30:0], 1'b0};
                        p_reg <= p_reg - 1'b1;
                    end
                end
                S_SQR: begin
                    frac_reg <= frac_next;
                    rnd_reg  <= rnd_reg + 1'b1;
                    if (rnd_reg == 4'd15 && !second_reg) begin
                        l1_reg     <= logv;
                        v_reg      <= ef_reg;
                        p_reg      <= 5'd31;
                        second_reg <= 1'b1;
                        state_reg  <= S_NORM;
                    end else begin
                        v_reg <= t[32] ? t[32:1] : t[31:0];
                        if (rnd_reg == 4'd15) begin
                            neg_reg   <= d[22];
                            mag_reg   <= d[22] ? 23'(-d) : 23'(d);
                            state_reg <= S_LNMUL;
                        end
                    end
                end
                S_LNMUL: begin
                    lnr_reg   <= lnprod[54:32];
                    state_reg <= S_OMUL;
                end
                S_OMUL: begin
                    olnr_reg  <= 41'($signed({1'b0, ent_reg.obs})) * 41'(lnr_s);
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (fin_go) begin
                        state_reg <= S_IDLE;
                        if (ent_reg.lc) begin
                            out_reg.flash_score         <= score;
                            out_reg.best_score          <= take_best ? score : best_reg;
                            out_reg.best_total_observed <= best_obs_new[21] ? '1
                                                           : best_obs_new[20:0];
                            out_reg.total_expected      <= exp_next;
                            out_reg.set_done            <= ent_reg.lf;
                            acc_reg                     <= '0;
                            obs_tot_reg                 <= '0;
                            exp_tot_reg                 <= '0;
                            if (ent_reg.lf) begin
                                best_reg      <= '0;
                                best_obs_reg  <= '0;
                                have_best_reg <= 1'b0;
                            end else if (take_best) begin
                                best_reg      <= score;
                                best_obs_reg  <= obs_next;
                                have_best_reg <= 1'b1;
                            end
                        end else begin
                            acc_reg     <= acc_next;
                            obs_tot_reg <= obs_next;
                            exp_tot_reg <= exp_next;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/poisson_likelihood_min_match_top.sv
// ----------------------------------------------------------------------------
// poisson_likelihood_min_match_top
// Poisson likelihood-ratio flash matcher with a running minimum score.
// ----------------------------------------------------------------------------
// Input channel s_*: one request per channel, tdata = {hypo_pe, observed_pe},
// tlast = last channel of the flash, tuser = last flash of the set.
// Result channel m_*: one result per flash on its last channel; tlast marks
// the end of the set, after which the best score state clears.
// Config channel cfg_*: writes scale_factor (Q4.12), always ready; write only
// while the block is idle.
// A channel with zero observed count goes from S_IDLE straight to S_FIN. Any
// other channel runs two log2 evaluations in one shared iterative unit: a
// one-bit-a-cycle normalize and 16 squaring rounds each, then the ln2 multiply
// and the observed-count multiply.
// A four-entry queue decouples request intake from the compute sequencer, so
// several channels are taken while one computes.
// Reset (aresetn low, synchronous) empties the queue, clears all totals and
// the best score and restores scale_factor to 1.0.
// When m_tready is low the result is held; a further last channel waits in the
// sequencer and the queue fills until s_tready drops.
// ----------------------------------------------------------------------------
module poisson_likelihood_min_match_top
    import plm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // observed_pe, hypo_pe
    input  logic         s_tlast,
    input  logic         s_tuser,   // last_flash
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // flash_score, best_score, best_total_observed,
                                    // total_expected, zero pad
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);

    entry_t  q_in;
    entry_t  q_out;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_valid;
    result_t res;

    assign cfg_ready = 1'b1;

    plm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .obs       (s_tdata[15:0]),
        .hypo      (s_tdata[31:16]),
        .lc        (s_tlast),
        .lf        (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    plm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .dvalid  (q_valid),
        .dout    (q_out)
    );

    plm_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {2'b0, res.total_expected, res.best_total_observed,
                      res.best_score, res.flash_score};
    assign m_tlast = res.set_done;

endmodule

FILE: rtl/plm_checker.sv
// ----------------------------------------------------------------------------
// plm_checker
// Port-level checks of the flash matcher, bound to the top level.
// ----------------------------------------------------------------------------
module plm_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic         m_tlast,
    input logic         cfg_ready
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result dropped or changed while stalled");

    a_best: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:32] <= m_tdata[31:0])
        else $error("best score above flash score");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[111:110] == 2'b00 && cfg_ready)
        else $error("pad bits set or config not ready");

endmodule

bind poisson_likelihood_min_match_top plm_checker u_plm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the Poisson likelihood flash matcher. Flashes of
// channel requests go through the stream input under random idling on both
// sides. A scoreboard class predicts each flash result in fixed point and
// checks it field by field against the result stream, over several
// scale_factor settings.
// ----------------------------------------------------------------------------
module tb;
    import plm_pkg::*;

    localparam int          CHANNELS  = CHANNELS_DEF;
    localparam int          AVG_SH    = $clog2(CHANNELS + 1) - 1;
    localparam int          LIMIT     = 2000000;
    localparam int          DRAIN     = 200;
    localparam longint      ACC_HI    = 64'sd549755813887;
    localparam longint      ACC_LO    = -64'sd549755813888;
    localparam logic [31:0] OBS_SAT   = 32'd4194303;
    localparam logic [31:0] EXP_SAT   = 32'd33554431;
    localparam logic [31:0] OUT_OBS   = 32'd2097151;

    typedef struct {
        logic [31:0] flash_score;
        logic [31:0] best_score;
        logic [20:0] best_obs;
        logic [24:0] total_exp;
        logic        set_done;
    } flash_res_t;

    class flash_scoreboard;
        logic [15:0] scale;
        longint      acc;
        logic [31:0] obs_tot, exp_tot, best, best_obs;
        bit          have_best;
        flash_res_t  pending_q[$];
        int          errors;

        function new();
            scale = SCALE_RESET;
            acc = 0; obs_tot = 0; exp_tot = 0;
            best = 0; best_obs = 0; have_best = 0;
            errors = 0;
        endfunction

        function longint log2_fix(logic [31:0] v);
            int          p;
            logic [63:0] y;
            longint      fr;
            p = 31;
            fr = 0;
            while (p > 0 && v[p] == 1'b0) p--;
            y = 64'(v) << (31 - p);
            for (int k = 0; k < 16; k++) begin
                y = (y * y) >> 31;
                fr = fr << 1;
                if (y >= 64'h1_0000_0000) begin
                    fr = fr | 1;
                    y = y >> 1;
                end
            end
            return (longint'(p) - 16) * 65536 + fr;
        endfunction

        function void note_request(logic [15:0] o, logic [15:0] h, bit lc, bit lf);
            logic [31:0] e, sum;
            longint      s, d, lnr, sc;
            logic [63:0] mag;
            flash_res_t  r;
            e = 32'(h) * 32'(scale);
            sum = obs_tot + 32'(o);
            obs_tot = (sum > OBS_SAT) ? OBS_SAT : sum;
            sum = exp_tot + (e >> 12);
            exp_tot = (sum > EXP_SAT) ? EXP_SAT : sum;
            if (o != 0 && e == 0) e = E_FLOOR;
            s = longint'(e) * 16 - longint'(o) * 65536;
            if (o != 0) begin
                d = log2_fix(32'(o) << 12) - log2_fix(e);
                mag = (d < 0) ? 64'(-d) : 64'(d);
                lnr = longint'((mag * 64'(LN2_Q32)) >> 32);
                if (d < 0) lnr = -lnr;
                s = s + longint'(o) * lnr;
            end
            acc = acc + ((2 * s) >>> 12);
            if (acc > ACC_HI) acc = ACC_HI;
            if (acc < ACC_LO) acc = ACC_LO;
            if (!lc) return;
            sc = acc >>> AVG_SH;
            if (sc < 0) r.flash_score = 0;
            else if (sc > 64'sd4294967295) r.flash_score = 32'hFFFF_FFFF;
            else r.flash_score = sc[31:0];
            if (!have_best || r.flash_score < best) begin
                best = r.flash_score;
                best_obs = obs_tot;
                have_best = 1;
            end
            r.best_score = best;
            r.best_obs = (best_obs > OUT_OBS) ? OUT_OBS[20:0] : best_obs[20:0];
            r.total_exp = exp_tot[24:0];
            r.set_done = lf;
            pending_q.push_back(r);
            acc = 0; obs_tot = 0; exp_tot = 0;
            if (lf) begin
                best = 0; best_obs = 0; have_best = 0;
            end
        endfunction

        function void check_result(logic [111:0] d, logic last);
            flash_res_t r;
            bit         bad;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h last %b", d, last);
                return;
            end
            r = pending_q.pop_front();
            bad = (d[31:0] !== r.flash_score) || (d[63:32] !== r.best_score) ||
                  (d[84:64] !== r.best_obs) || (d[109:85] !== r.total_exp) ||
                  (last !== r.set_done);
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch score exp %h got %h, best exp %h got %h",
                             r.flash_score, d[31:0], r.best_score, d[63:32]);
                    $display("  best_obs exp %h got %h, total_exp exp %h got %h, done %b/%b",
                             r.best_obs, d[84:64], r.total_exp, d[109:85],
                             r.set_done, last);
                end
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;  // observed_pe, hypo_pe
    logic         s_tlast = 0;
    logic         s_tuser = 0;   // last_flash
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [111:0] m_tdata;       // flash_score, best_score, best_total_observed,
                                 // total_expected, zero pad
    logic         m_tlast;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [15:0]  cfg_data = '0;

    flash_scoreboard sb = new();
    int src_idle = 37;
    int dst_idle = 80;
    int cycles = 0;

    always #5 aclk = ~aclk;

    poisson_likelihood_min_match_top #(.CHANNELS(CHANNELS)) DUT (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= dst_idle);
    end

    task automatic send_request(logic [15:0] o, logic [15:0] h, bit lc, bit lf);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {h, o};
        s_tlast <= lc;
        s_tuser <= lf;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(o, h, lc, lf);
    endtask

    task automatic write_scale(logic [15:0] v);
        s_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.scale = v;
    endtask

    function automatic logic [15:0] rand_count();
        case ($urandom_range(4))
            0: return 16'd0;
            1: return 16'($urandom_range(1, 255));
            2: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_flashes(int n);
        int len;
        bit lf;
        while (n > 0) begin
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 40);
            lf = ($urandom_range(3) == 0);
            for (int i = 0; i < len; i++) begin
                send_request(rand_count(), rand_count(), i == len - 1,
                             (i == len - 1) ? lf : ($urandom_range(7) == 0));
            end
            n -= len;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // zero expected with observed, zero observed, extremes
        send_request(16'd0, 16'd0, 0, 0);
        send_request(16'hFFFF, 16'd0, 0, 1);
        send_request(16'd0, 16'hFFFF, 0, 0);
        send_request(16'hFFFF, 16'hFFFF, 1, 0);
        send_request(16'd1, 16'd1, 0, 0);
        send_request(16'd16, 16'd16, 1, 0);
        // tie with the previous flash
        send_request(16'd1, 16'd1, 0, 0);
        send_request(16'd16, 16'd16, 1, 0);
        send_request(16'h8000, 16'h0001, 0, 0);
        send_request(16'h0001, 16'h8000, 1, 1);
        send_request(16'd100, 16'd100, 1, 1);
        for (int i = 0; i < 6; i++) send_request(16'hFFFF, 16'hFFFF, i == 5, 1);
        write_scale(16'd0);
        random_flashes(320);
        write_scale(16'hFFFF);
        random_flashes(320);
        src_idle = 80; dst_idle = 37;
        write_scale(16'($urandom_range(0, 65535)));
        random_flashes(320);
        write_scale(16'd1);
        random_flashes(320);
        src_idle = 0; dst_idle = 0;
        write_scale(16'($urandom_range(0, 65535)));
        random_flashes(320);
        // long flash well past CHANNELS
        write_scale(16'hFFFF);
        for (int i = 0; i < 400; i++) send_request(16'd0, 16'hFFFF, i == 399, 1);
        send_request(16'd0, 16'hFFFF, 1, 1);
        s_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/plm_pkg.sv
rtl/plm_front.sv
rtl/plm_queue.sv
rtl/plm_back.sv
rtl/poisson_likelihood_min_match_top.sv
rtl/plm_checker.sv
tb/sv/tb.sv
